// ----- rtl/core/sorted_priority_table_defines.svh -----
// assertion macros for the sorted priority table
// used by the top level only, no dependencies
`ifndef SORTED_PRIORITY_TABLE_DEFINES_SVH
`define SORTED_PRIORITY_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

`define SPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_table: implication failed");

`define SPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_table: next-cycle check failed");

`else

`define SPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/sptab_pkg.sv -----
// shared types, constants and helpers for the sorted priority table
// no dependencies
package sptab_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 5;
    localparam int CMD_W       = 3;
    localparam int KEY_W       = 64;
    localparam int AGE_W       = 7;
    localparam int LVL_W       = 3;
    localparam int POS_W       = 4;
    localparam int ST_W        = 3;

    localparam logic [LVL_W-1:0] LEVEL_MIN = 3'd1;
    localparam logic [LVL_W-1:0] LEVEL_MAX = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_CHANGE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_LEVEL = 3'd3,
        ST_NO_POS    = 3'd4
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
        logic [LVL_W-1:0] level;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIND_RD,
        S_FIND_CHK,
        S_DROP_RD,
        S_DROP_WR,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_SHIFT,
        S_SHIFT_WR,
        S_POS_RD,
        S_POS_CHK,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        ADDR_IDX,
        ADDR_NEXT,
        ADDR_PREV,
        ADDR_POS
    } t_addr_sel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CLEAR,
        IDX_INC,
        IDX_DEC,
        IDX_COUNT
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_ERR,
        RES_READ,
        RES_NEW
    } t_res_op;

    typedef struct packed {
        logic      in_ready;
        logic      load;
        logic      rd_en;
        t_addr_sel rd_sel;
        logic      wr_en;
        logic      wr_new;
        t_idx_op   idx_op;
        logic      slot_load;
        t_cnt_op   cnt_op;
        t_res_op   res_op;
        t_status   res_status;
        logic      age_load;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic             in_valid;
        logic             out_free;
        logic [CMD_W-1:0] cmd;
        logic             lvl_ok;
        logic             full;
        logic             scan_end;
        logic             key_hit;
        logic             lvl_ge;
        logic             pos_ok;
        logic             drop_more;
        logic             shift_more;
    } t_dp_stat;

    function automatic logic level_ok(input logic [LVL_W-1:0] lvl);
        return (lvl >= LEVEL_MIN) && (lvl <= LEVEL_MAX);
    endfunction

endpackage

// ----- rtl/core/sptab_req_if.sv -----
// command channel of the sorted priority table
// depends on sptab_pkg
interface sptab_req_if import sptab_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] customer_key;
    logic [AGE_W-1:0] customer_age;
    logic [LVL_W-1:0] priority_level;
    logic [POS_W-1:0] position;

    modport source (
        output valid, command, customer_key, customer_age, priority_level, position,
        input  ready
    );
    modport sink (
        input  valid, command, customer_key, customer_age, priority_level, position,
        output ready
    );
endinterface

// ----- rtl/core/sptab_rsp_if.sv -----
// result channel of the sorted priority table
// depends on sptab_pkg
interface sptab_rsp_if import sptab_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] found_key;
    logic [AGE_W-1:0] found_age;
    logic [LVL_W-1:0] found_level;
    logic [CNT_W-1:0] entry_count;

    modport source (
        output valid, status, found_key, found_age, found_level, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_key, found_age, found_level, entry_count,
        output ready
    );
endinterface

// ----- rtl/core/sptab_ctrl.sv -----
// command sequencer: scan, shift and place steps over the entry memory
// depends on sptab_pkg
module sptab_ctrl
    import sptab_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_INSERT: begin
                        n_state = (i_stat.lvl_ok && !i_stat.full) ? S_SLOT_RD : S_FINISH;
                    end
                    CMD_REMOVE, CMD_CHANGE, CMD_SEARCH: n_state = S_FIND_RD;
                    CMD_READ:   n_state = i_stat.pos_ok ? S_POS_RD : S_FINISH;
                    default:    n_state = S_FINISH;
                endcase
            end
            S_FIND_RD: begin
                n_state = i_stat.scan_end ? S_FINISH : S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (!i_stat.key_hit) begin
                    n_state = S_FIND_RD;
                end else if (i_stat.cmd == CMD_REMOVE) begin
                    n_state = S_DROP_RD;
                end else if (i_stat.cmd == CMD_CHANGE && i_stat.lvl_ok) begin
                    n_state = S_DROP_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DROP_RD: begin
                if (i_stat.drop_more) begin
                    n_state = S_DROP_WR;
                end else if (i_stat.cmd == CMD_CHANGE) begin
                    n_state = S_SLOT_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DROP_WR:  n_state = S_DROP_RD;
            S_SLOT_RD:  n_state = i_stat.scan_end ? S_SHIFT : S_SLOT_CHK;
            S_SLOT_CHK: n_state = i_stat.lvl_ge ? S_SLOT_RD : S_SHIFT;
            S_SHIFT:    n_state = i_stat.shift_more ? S_SHIFT_WR : S_FINISH;
            S_SHIFT_WR: n_state = S_SHIFT;
            S_POS_RD:   n_state = S_POS_CHK;
            S_POS_CHK:  n_state = S_FINISH;
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_sel     = ADDR_IDX;
        o_cmd.idx_op     = IDX_HOLD;
        o_cmd.cnt_op     = CNT_HOLD;
        o_cmd.res_op     = RES_HOLD;
        o_cmd.res_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = i_rst_n;
                o_cmd.load     = i_stat.in_valid && i_rst_n;
                o_cmd.idx_op   = IDX_CLEAR;
            end
            S_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_INSERT: begin
                        if (!i_stat.lvl_ok) begin
                            o_cmd.res_op     = RES_ERR;
                            o_cmd.res_status = ST_BAD_LEVEL;
                        end else if (i_stat.full) begin
                            o_cmd.res_op     = RES_ERR;
                            o_cmd.res_status = ST_FULL;
                        end
                    end
                    CMD_REMOVE, CMD_CHANGE, CMD_SEARCH: begin
                    end
                    CMD_READ: begin
                        if (!i_stat.pos_ok) begin
                            o_cmd.res_op     = RES_ERR;
                            o_cmd.res_status = ST_NO_POS;
                        end
                    end
                    default: begin
                        o_cmd.res_op     = RES_ERR;
                        o_cmd.res_status = ST_OK;
                    end
                endcase
            end
            S_FIND_RD: begin
                if (i_stat.scan_end) begin
                    o_cmd.res_op     = RES_ERR;
                    o_cmd.res_status = ST_NOT_FOUND;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ADDR_IDX;
                end
            end
            S_FIND_CHK: begin
                if (!i_stat.key_hit) begin
                    o_cmd.idx_op = IDX_INC;
                end else if (i_stat.cmd == CMD_CHANGE) begin
                    if (i_stat.lvl_ok) begin
                        o_cmd.age_load = 1'b1;
                    end else begin
                        o_cmd.res_op     = RES_ERR;
                        o_cmd.res_status = ST_BAD_LEVEL;
                    end
                end else begin
                    o_cmd.res_op = RES_READ;
                end
            end
            S_DROP_RD: begin
                if (i_stat.drop_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ADDR_NEXT;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                    o_cmd.idx_op = IDX_CLEAR;
                end
            end
            S_DROP_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = IDX_INC;
            end
            S_SLOT_RD: begin
                if (i_stat.scan_end) begin
                    o_cmd.slot_load = 1'b1;
                    o_cmd.idx_op    = IDX_COUNT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ADDR_IDX;
                end
            end
            S_SLOT_CHK: begin
                if (i_stat.lvl_ge) begin
                    o_cmd.idx_op = IDX_INC;
                end else begin
                    o_cmd.slot_load = 1'b1;
                    o_cmd.idx_op    = IDX_COUNT;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ADDR_PREV;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_new = 1'b1;
                    o_cmd.cnt_op = CNT_INC;
                    o_cmd.res_op = RES_NEW;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = IDX_DEC;
            end
            S_POS_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ADDR_POS;
            end
            S_POS_CHK: begin
                o_cmd.res_op = RES_READ;
            end
            S_FINISH: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/core/sptab_dp.sv -----
// entry memory, scan index, entry count, result and output registers
// depends on sptab_pkg, sptab_req_if, sptab_rsp_if
module sptab_dp
    import sptab_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    sptab_req_if.sink   i_req,
    sptab_rsp_if.source o_rsp,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat
);

    t_entry             r_mem [QUEUE_DEPTH];
    t_entry             r_rd_data;
    logic [CMD_W-1:0]   r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [AGE_W-1:0]   r_age;
    logic [LVL_W-1:0]   r_lvl;
    logic [POS_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   n_idx;
    logic [CNT_W-1:0]   r_slot;
    logic [CNT_W-1:0]   r_count;
    logic [ST_W-1:0]    r_res_status;
    t_entry             r_res;
    logic               r_out_valid;
    logic [ST_W-1:0]    r_out_status;
    t_entry             r_out;
    logic [CNT_W-1:0]   r_out_count;
    logic [CNT_W-1:0]   w_rd_addr;
    logic [CNT_W-1:0]   w_idx_next;
    t_entry             w_wr_data;

    assign w_idx_next = r_idx + CNT_W'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            ADDR_IDX:  w_rd_addr = r_idx;
            ADDR_NEXT: w_rd_addr = w_idx_next;
            ADDR_PREV: w_rd_addr = r_idx - CNT_W'(1);
            ADDR_POS:  w_rd_addr = CNT_W'(r_pos);
            default:   w_rd_addr = r_idx;
        endcase
    end

    assign w_wr_data = i_cmd.wr_new ? t_entry'{key: r_key, age: r_age, level: r_lvl}
                                    : r_rd_data;

    // entry memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_idx[IDX_W-1:0]] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr[IDX_W-1:0]];
        end
    end

    // captured command fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_req.command;
            r_key <= i_req.customer_key;
            r_age <= i_req.customer_age;
            r_lvl <= i_req.priority_level;
            r_pos <= i_req.position;
        end else if (i_cmd.age_load) begin
            r_age <= r_rd_data.age;
        end
    end

    always_comb begin
        unique case (i_cmd.idx_op)
            IDX_HOLD:  n_idx = r_idx;
            IDX_CLEAR: n_idx = '0;
            IDX_INC:   n_idx = w_idx_next;
            IDX_DEC:   n_idx = r_idx - CNT_W'(1);
            IDX_COUNT: n_idx = r_count;
            default:   n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_idx <= n_idx;
            unique case (i_cmd.cnt_op)
                CNT_HOLD: r_count <= r_count;
                CNT_INC:  r_count <= r_count + CNT_W'(1);
                CNT_DEC:  r_count <= r_count - CNT_W'(1);
                default:  r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.slot_load) begin
            r_slot <= r_idx;
        end
    end

    // result of the command in flight
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.res_op)
            RES_HOLD: begin
            end
            RES_ERR: begin
                r_res_status <= i_cmd.res_status;
                r_res        <= '0;
            end
            RES_READ: begin
                r_res_status <= ST_OK;
                r_res        <= r_rd_data;
            end
            RES_NEW: begin
                r_res_status <= ST_OK;
                r_res        <= t_entry'{key: r_key, age: r_age, level: r_lvl};
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out        <= r_res;
            r_out_count  <= r_count;
        end
    end

    assign i_req.ready       = i_cmd.in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_key   = r_out.key;
    assign o_rsp.found_age   = r_out.age;
    assign o_rsp.found_level = r_out.level;
    assign o_rsp.entry_count = r_out_count;

    always_comb begin
        o_stat.in_valid   = i_req.valid;
        o_stat.out_free   = !r_out_valid || o_rsp.ready;
        o_stat.cmd        = r_cmd;
        o_stat.lvl_ok     = level_ok(r_lvl);
        o_stat.full       = r_count >= CNT_W'(QUEUE_DEPTH);
        o_stat.scan_end   = r_idx >= r_count;
        o_stat.key_hit    = r_rd_data.key == r_key;
        o_stat.lvl_ge     = r_rd_data.level >= r_lvl;
        o_stat.pos_ok     = CNT_W'(r_pos) < r_count;
        o_stat.drop_more  = w_idx_next < r_count;
        o_stat.shift_more = r_idx > r_slot;
    end

endmodule

// ----- rtl/core/sorted_priority_table.sv -----
// sorted priority table top level: sequencer plus datapath, one command at a time
// every visited entry costs a read step and a compare or write step on the entry memory
// a new command is taken only from idle, in the cycle after the previous result is loaded
// reset: synchronous, active low; clears the count and output valid, table contents kept
`include "sorted_priority_table_defines.svh"

module sorted_priority_table
    import sptab_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sptab_req_if.sink   i_in,
    sptab_rsp_if.source o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sptab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    sptab_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in),
        .o_rsp   (o_out),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    `SPT_ASSERT_IMPLY(a_err_fields_zero, i_clk, i_rst_n, o_out.valid && o_out.status != ST_OK, o_out.found_key == '0 && o_out.found_age == '0 && o_out.found_level == '0)
    `SPT_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, o_out.valid, o_out.entry_count <= CNT_W'(QUEUE_DEPTH))
    `SPT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `SPT_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, w_cmd.out_load, o_out.valid)

endmodule

// ----- tb/sv/table_check_pkg.sv -----
// scoreboard for the sorted priority table: mirror of the table, expected results and compare
// depends on sptab_pkg
`timescale 1ns / 100ps

package table_check_pkg;
    import sptab_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
        logic [LVL_W-1:0] level;
        logic [POS_W-1:0] position;
    } t_table_cmd;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
        logic [LVL_W-1:0] level;
        logic [CNT_W-1:0] count;
    } t_table_rsp;

    class table_scoreboard;
        logic [KEY_W-1:0] held_keys[QUEUE_DEPTH];
        logic [AGE_W-1:0] held_ages[QUEUE_DEPTH];
        logic [LVL_W-1:0] held_levels[QUEUE_DEPTH];
        int unsigned      held_count;
        t_table_rsp       expected_results[$];
        int unsigned      commands_noted;
        int unsigned      results_checked;
        int unsigned      mismatch_count;
        int unsigned      peak_count;
        int unsigned      status_seen[5];

        function new();
            held_count      = 0;
            commands_noted  = 0;
            results_checked = 0;
            mismatch_count  = 0;
            peak_count      = 0;
            foreach (held_keys[i]) begin
                held_keys[i]   = '0;
                held_ages[i]   = '0;
                held_levels[i] = '0;
            end
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function bit level_valid(logic [LVL_W-1:0] lvl);
            return (lvl >= LEVEL_MIN) && (lvl <= LEVEL_MAX);
        endfunction

        // frontmost match, or held_count when absent
        function int unsigned find_key(logic [KEY_W-1:0] key);
            int unsigned i;
            i = 0;
            while (i < held_count && held_keys[i] !== key) i++;
            return i;
        endfunction

        function void drop_at(int unsigned idx);
            for (int unsigned i = idx; i + 1 < held_count; i++) begin
                held_keys[i]   = held_keys[i+1];
                held_ages[i]   = held_ages[i+1];
                held_levels[i] = held_levels[i+1];
            end
            held_count--;
        endfunction

        // goes behind every entry of equal or higher level
        function void place(logic [KEY_W-1:0] key, logic [AGE_W-1:0] age,
                            logic [LVL_W-1:0] lvl);
            int unsigned slot;
            slot = 0;
            while (slot < held_count && held_levels[slot] >= lvl) slot++;
            for (int unsigned i = held_count; i > slot; i--) begin
                held_keys[i]   = held_keys[i-1];
                held_ages[i]   = held_ages[i-1];
                held_levels[i] = held_levels[i-1];
            end
            held_keys[slot]   = key;
            held_ages[slot]   = age;
            held_levels[slot] = lvl;
            held_count++;
            if (held_count > peak_count) peak_count = held_count;
        endfunction

        function void note_command(t_table_cmd c);
            t_table_rsp       r;
            int unsigned      idx;
            logic [AGE_W-1:0] kept_age;
            r = '0;
            r.status = ST_OK;
            case (c.command)
                CMD_INSERT: begin
                    if (!level_valid(c.level)) begin
                        r.status = ST_BAD_LEVEL;
                    end else if (held_count >= QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        place(c.key, c.age, c.level);
                        r.key   = c.key;
                        r.age   = c.age;
                        r.level = c.level;
                    end
                end
                CMD_REMOVE: begin
                    idx = find_key(c.key);
                    if (idx >= held_count) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.key   = held_keys[idx];
                        r.age   = held_ages[idx];
                        r.level = held_levels[idx];
                        drop_at(idx);
                    end
                end
                CMD_CHANGE: begin
                    idx = find_key(c.key);
                    if (idx >= held_count) begin
                        r.status = ST_NOT_FOUND;
                    end else if (!level_valid(c.level)) begin
                        r.status = ST_BAD_LEVEL;
                    end else begin
                        kept_age = held_ages[idx];
                        drop_at(idx);
                        place(c.key, kept_age, c.level);
                        r.key   = c.key;
                        r.age   = kept_age;
                        r.level = c.level;
                    end
                end
                CMD_SEARCH: begin
                    idx = find_key(c.key);
                    if (idx >= held_count) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.key   = held_keys[idx];
                        r.age   = held_ages[idx];
                        r.level = held_levels[idx];
                    end
                end
                CMD_READ: begin
                    if (c.position >= held_count) begin
                        r.status = ST_NO_POS;
                    end else begin
                        r.key   = held_keys[c.position];
                        r.age   = held_ages[c.position];
                        r.level = held_levels[c.position];
                    end
                end
                default: begin
                end
            endcase
            r.count = CNT_W'(held_count);
            status_seen[r.status]++;
            commands_noted++;
            expected_results.push_back(r);
        endfunction

        function void log_mismatch(string why, t_table_rsp want, t_table_rsp got);
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch (%s) at %0t", why, $realtime);
                $display("  expected st=%0d key=%h age=%0d lvl=%0d cnt=%0d",
                         want.status, want.key, want.age, want.level, want.count);
                $display("  actual   st=%0d key=%h age=%0d lvl=%0d cnt=%0d",
                         got.status, got.key, got.age, got.level, got.count);
            end
        endfunction

        function void check_result(t_table_rsp got);
            t_table_rsp want;
            results_checked++;
            if (expected_results.size() == 0) begin
                log_mismatch("result with nothing expected", '0, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.key !== want.key ||
                got.age !== want.age || got.level !== want.level ||
                got.count !== want.count)
                log_mismatch("field differs", want, got);
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// top testbench for sorted_priority_table: directed then random commands with random stalls
// depends on sptab_pkg, sptab_req_if, sptab_rsp_if and table_check_pkg
`timescale 1ns / 100ps

module tb_top;
    import sptab_pkg::*;
    import table_check_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int POOL_SIZE    = 20;
    localparam int PHASE_LEN    = 60;

    localparam logic [KEY_W-1:0] KEY_A       = 64'h0123_4567_89AB_CDEF;
    localparam logic [KEY_W-1:0] KEY_B       = 64'h4E41_4D45_5F42_0000;
    localparam logic [KEY_W-1:0] KEY_MISSING = 64'h5A5A_A5A5_0F0F_F0F0;
    localparam logic [KEY_W-1:0] KEY_ONES    = '1;
    localparam logic [KEY_W-1:0] KEY_ZERO    = '0;

    logic            i_clk;
    logic            i_rst_n;
    bit              steady;
    int unsigned     cycle_count = 0;
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    table_scoreboard sb;

    sptab_req_if req_ch();
    sptab_rsp_if rsp_ch();

    sorted_priority_table uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(t_table_rsp'{rsp_ch.status, rsp_ch.found_key,
                    rsp_ch.found_age, rsp_ch.found_level, rsp_ch.entry_count});
            rsp_ch.ready <= steady || ($urandom_range(99) >= 15);
        end
    end

    function automatic t_table_cmd make_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                            logic [AGE_W-1:0] age, logic [LVL_W-1:0] lvl,
                                            logic [POS_W-1:0] pos);
        return t_table_cmd'{cmd, key, age, lvl, pos};
    endfunction

    task automatic send_command(t_table_cmd c);
        int unsigned gap;
        gap = (!steady && $urandom_range(99) < 15) ? $urandom_range(4, 1) : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= c.command;
        req_ch.customer_key   <= c.key;
        req_ch.customer_age   <= c.age;
        req_ch.priority_level <= c.level;
        req_ch.position       <= c.position;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_command(c);
    endtask

    // mode 0 fills the table, mode 1 drains it, mode 2 mixes all commands with inserts ahead of removes
    function automatic t_table_cmd random_command(int unsigned mode);
        int unsigned      pick;
        int unsigned      n;
        int unsigned      th_ins, th_rem, th_chg, th_srch;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [LVL_W-1:0] lvl;
        logic [POS_W-1:0] pos;
        n = sb.held_count;
        case (mode)
            0:       begin th_ins = 65; th_rem = 75; th_chg = 83; th_srch = 91; end
            1:       begin th_ins = 15; th_rem = 60; th_chg = 72; th_srch = 86; end
            default: begin th_ins = 30; th_rem = 50; th_chg = 65; th_srch = 80; end
        endcase
        pick = $urandom_range(99);
        if (pick < th_ins)       cmd = CMD_INSERT;
        else if (pick < th_rem)  cmd = CMD_REMOVE;
        else if (pick < th_chg)  cmd = CMD_CHANGE;
        else if (pick < th_srch) cmd = CMD_SEARCH;
        else                     cmd = CMD_READ;
        if (cmd != CMD_INSERT && n != 0 && $urandom_range(99) < 70)
            key = sb.held_keys[$urandom_range(n - 1)];
        else if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else
            key = {$urandom, $urandom};
        lvl = ($urandom_range(99) < 12) ? LVL_W'($urandom_range(7))
                                        : LVL_W'($urandom_range(4, 1));
        pos = (n != 0 && $urandom_range(99) < 75) ? POS_W'($urandom_range(n - 1))
                                                  : POS_W'($urandom_range(15));
        return make_cmd(cmd, key, AGE_W'($urandom_range(127)), lvl, pos);
    endfunction

    task automatic run_directed();
        send_command(make_cmd(CMD_INSERT, KEY_ONES, 7'd127, 3'd4, 4'd0));
        send_command(make_cmd(CMD_INSERT, KEY_ZERO, 7'd0, 3'd1, 4'd15));
        send_command(make_cmd(CMD_INSERT, KEY_A, 7'd5, 3'd2, 4'd0));
        send_command(make_cmd(CMD_INSERT, KEY_B, 7'd9, 3'd2, 4'd0));
        send_command(make_cmd(CMD_INSERT, KEY_A, 7'd33, 3'd0, 4'd0));
        send_command(make_cmd(CMD_INSERT, KEY_A, 7'd33, 3'd5, 4'd0));
        send_command(make_cmd(CMD_INSERT, KEY_A, 7'd33, 3'd7, 4'd0));
        send_command(make_cmd(CMD_INSERT, KEY_A, 7'd64, 3'd3, 4'd0));
        send_command(make_cmd(CMD_SEARCH, KEY_A, 7'd0, 3'd0, 4'd0));
        send_command(make_cmd(CMD_SEARCH, KEY_MISSING, 7'd0, 3'd0, 4'd0));
        send_command(make_cmd(CMD_SEARCH, KEY_ZERO, 7'd0, 3'd0, 4'd0));
        send_command(make_cmd(CMD_READ, KEY_ZERO, 7'd0, 3'd0, 4'd0));
        send_command(make_cmd(CMD_READ, KEY_ZERO, 7'd0, 3'd0, 4'd4));
        send_command(make_cmd(CMD_READ, KEY_ZERO, 7'd0, 3'd0, 4'd5));
        send_command(make_cmd(CMD_READ, KEY_ONES, 7'd127, 3'd7, 4'd15));
        send_command(make_cmd(CMD_CHANGE, KEY_MISSING, 7'd0, 3'd6, 4'd0));
        send_command(make_cmd(CMD_CHANGE, KEY_B, 7'd0, 3'd0, 4'd0));
        send_command(make_cmd(CMD_CHANGE, KEY_B, 7'd0, 3'd2, 4'd0));
        send_command(make_cmd(CMD_CHANGE, KEY_ZERO, 7'd0, 3'd4, 4'd0));
        send_command(make_cmd(CMD_REMOVE, KEY_ONES, 7'd0, 3'd0, 4'd0));
        send_command(make_cmd(CMD_REMOVE, KEY_A, 7'd0, 3'd0, 4'd0));
        send_command(make_cmd(CMD_REMOVE, KEY_MISSING, 7'd0, 3'd0, 4'd0));
        send_command(make_cmd(CMD_READ, KEY_ZERO, 7'd0, 3'd0, 4'd0));
    endtask

    initial begin
        sb = new();
        steady = 1'b0;
        key_pool[0] = KEY_ZERO;
        key_pool[1] = KEY_ONES;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_INSERT;
        req_ch.customer_key   = '0;
        req_ch.customer_age   = '0;
        req_ch.priority_level = '0;
        req_ch.position       = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 400 && i < 600);
            send_command(random_command((i / PHASE_LEN) % 3));
        end
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d commands, %0d results checked, peak occupancy %0d of %0d, %0d mismatches",
                 sb.commands_noted, sb.results_checked, sb.peak_count, QUEUE_DEPTH,
                 sb.mismatch_count);
        $display("status mix: ok %0d, not found %0d, full %0d, bad level %0d, no position %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_BAD_LEVEL], sb.status_seen[ST_NO_POS]);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sorted_priority_table.f -----
+incdir+rtl/core
rtl/core/sptab_pkg.sv
rtl/core/sptab_req_if.sv
rtl/core/sptab_rsp_if.sv
rtl/core/sptab_ctrl.sv
rtl/core/sptab_dp.sv
rtl/core/sorted_priority_table.sv
tb/sv/table_check_pkg.sv
tb/sv/tb_top.sv
